>>> rtl/ogr_pkg.sv
// Shared types and constants of the occupancy grid resample unit.
`timescale 1ns / 1ps
`default_nettype none

package ogr_pkg;

  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CFG_SOURCE_WIDTH       = 2'd0,
    CFG_SOURCE_HEIGHT      = 2'd1,
    CFG_SCALE_RATIO        = 2'd2,
    CFG_OCCUPIED_THRESHOLD = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  localparam logic [8:0]  SOURCE_SIDE_RST = 9'd256;
  localparam logic [15:0] SCALE_RATIO_RST = 16'd256;
  localparam logic [6:0]  THRESHOLD_RST   = 7'd50;

  typedef struct packed {
    logic               operation;
    logic [15:0]        col;
    logic [15:0]        row;
    logic signed [7:0]  cell_value;
  } in_item_t;

  typedef struct packed {
    logic was_query;
    logic occupied;
  } out_item_t;

  typedef struct packed {
    cfg_idx_e                index;
    logic [CFG_DATA_W-1:0]   data;
  } cfg_item_t;

endpackage

`default_nettype wire

>>> rtl/ogr_if.sv
// Handshake channel interfaces for requests, results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface ogr_in_if;
  logic               valid;
  logic               ready;
  ogr_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ogr_out_if;
  logic               valid;
  logic               ready;
  ogr_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ogr_cfg_if;
  logic                                valid;
  logic                                ready;
  ogr_pkg::cfg_idx_e                   index;
  logic [ogr_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/occupancy_grid_or_pool_resample_unit.sv
// Occupancy grid resample unit: a write stores one cell if it lies inside the source grid
// and is answered in the cycle after it is taken. A query makes two passes through the
// shared multiply and window unit, then one cell store read per cycle; it ends early on
// the first occupied or unknown cell. One item is in work at a time.
// Reset sets the sequencer idle and the registers to their defaults; the cell store is
// not cleared and holds nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_or_pool_resample_unit #(
  parameter int MAX_SIDE        = 256,
  parameter int RATIO_FRAC_BITS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ogr_cfg_if.sink    cfg_i,
  ogr_in_if.sink     in_i,
  ogr_out_if.source  out_o
);

  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SZ_W   = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SZ_W > 9) ? SZ_W : 9;
  localparam int AW     = 2 * SIDE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XWIN,
    S_YWIN,
    S_SCAN
  } state_e;

  state_e               state_q;
  logic [8:0]           width_q;
  logic [8:0]           height_q;
  logic [15:0]          ratio_q;
  logic [6:0]           thr_q;
  logic [15:0]          col_q;
  logic [15:0]          row_q;
  logic                 start_q;
  logic                 x_empty_q;
  logic [SIDE_W-1:0]    x0_q;
  logic [SIDE_W-1:0]    x1_q;
  logic [SIDE_W-1:0]    y1_q;
  logic [SIDE_W-1:0]    x_q;
  logic [SIDE_W-1:0]    y_q;
  logic                 issued_all_q;
  logic                 chk_q;
  logic                 chk_last_q;
  logic                 out_valid_q;
  ogr_pkg::out_item_t   out_q;

  logic [SZ_W-1:0]      width_use;
  logic [SZ_W-1:0]      height_use;
  logic                 in_ready;
  logic                 in_take;
  logic                 wr_en;
  logic                 rd_en;
  logic                 last_cell;
  logic [7:0]           rdata;
  logic                 hit;
  logic                 axis_done;
  logic                 axis_empty;
  logic [SIDE_W-1:0]    axis_lo;
  logic [SIDE_W-1:0]    axis_hi;
  logic [SZ_W-1:0]      axis_size;
  logic [15:0]          axis_t;

  assign width_use  = (CMP_W'(width_q) > CMP_W'(MAX_SIDE)) ? SZ_W'(MAX_SIDE) : SZ_W'(width_q);
  assign height_use = (CMP_W'(height_q) > CMP_W'(MAX_SIDE)) ? SZ_W'(MAX_SIDE) : SZ_W'(height_q);

  assign cfg_i.ready   = 1'b1;
  assign in_ready      = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_i.ready    = in_ready;
  assign in_take       = in_i.valid && in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign wr_en = in_take && (in_i.payload.operation == ogr_pkg::OP_WRITE)
                 && (in_i.payload.col < 16'(width_use))
                 && (in_i.payload.row < 16'(height_use));

  assign rd_en     = (state_q == S_SCAN) && !issued_all_q;
  assign last_cell = (x_q == x1_q) && (y_q == y1_q);

  // A negative cell is unknown and counts as occupied.
  assign hit = rdata[7] || (rdata[6:0] >= thr_q);

  assign axis_t    = (state_q == S_XWIN) ? col_q : row_q;
  assign axis_size = (state_q == S_XWIN) ? width_use : height_use;

  ogr_axis_unit #(
    .SIDE_W          (SIDE_W),
    .SZ_W            (SZ_W),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_axis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .t_i     (axis_t),
    .ratio_i (ratio_q),
    .size_i  (axis_size),
    .done_o  (axis_done),
    .empty_o (axis_empty),
    .lo_o    (axis_lo),
    .hi_o    (axis_hi)
  );

  ogr_cell_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i ({in_i.payload.row[SIDE_W-1:0], in_i.payload.col[SIDE_W-1:0]}),
    .wdata_i (in_i.payload.cell_value),
    .re_i    (rd_en),
    .raddr_i ({y_q, x_q}),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      width_q      <= ogr_pkg::SOURCE_SIDE_RST;
      height_q     <= ogr_pkg::SOURCE_SIDE_RST;
      ratio_q      <= ogr_pkg::SCALE_RATIO_RST;
      thr_q        <= ogr_pkg::THRESHOLD_RST;
      start_q      <= 1'b0;
      issued_all_q <= 1'b0;
      chk_q        <= 1'b0;
      chk_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      start_q <= 1'b0;

      if (cfg_i.valid) begin
        case (cfg_i.index)
          ogr_pkg::CFG_SOURCE_WIDTH:       width_q  <= cfg_i.data[8:0];
          ogr_pkg::CFG_SOURCE_HEIGHT:      height_q <= cfg_i.data[8:0];
          ogr_pkg::CFG_SCALE_RATIO:        ratio_q  <= cfg_i.data;
          ogr_pkg::CFG_OCCUPIED_THRESHOLD: thr_q    <= cfg_i.data[6:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            if (in_i.payload.operation == ogr_pkg::OP_WRITE) begin
              out_valid_q     <= 1'b1;
              out_q.was_query <= 1'b0;
              out_q.occupied  <= 1'b0;
            end else begin
              col_q   <= in_i.payload.col;
              row_q   <= in_i.payload.row;
              start_q <= 1'b1;
              state_q <= S_XWIN;
            end
          end
        end
        S_XWIN: begin
          if (axis_done) begin
            x_empty_q <= axis_empty;
            x0_q      <= axis_lo;
            x1_q      <= axis_hi;
            start_q   <= 1'b1;
            state_q   <= S_YWIN;
          end
        end
        S_YWIN: begin
          if (axis_done) begin
            if (x_empty_q || axis_empty) begin
              out_valid_q     <= 1'b1;
              out_q.was_query <= 1'b1;
              out_q.occupied  <= 1'b0;
              state_q         <= S_IDLE;
            end else begin
              x_q          <= x0_q;
              y_q          <= axis_lo;
              y1_q         <= axis_hi;
              issued_all_q <= 1'b0;
              chk_q        <= 1'b0;
              chk_last_q   <= 1'b0;
              state_q      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Reads are issued one per cycle; each read is checked in the cycle after it is issued.
          chk_q      <= rd_en;
          chk_last_q <= rd_en && last_cell;
          if (rd_en) begin
            if (x_q == x1_q) begin
              x_q <= x0_q;
              if (y_q == y1_q) begin
                issued_all_q <= 1'b1;
              end else begin
                y_q <= y_q + 1'b1;
              end
            end else begin
              x_q <= x_q + 1'b1;
            end
          end
          if (chk_q && (hit || chk_last_q)) begin
            out_valid_q     <= 1'b1;
            out_q.was_query <= 1'b1;
            out_q.occupied  <= hit;
            chk_q           <= 1'b0;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/ogr_cell_mem.sv
// Cell store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ogr_cell_mem #(
  parameter int AW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ogr_axis_unit.sv
// Shared window unit: one multiply, then the clamped source window of one axis.
`timescale 1ns / 1ps
`default_nettype none

module ogr_axis_unit #(
  parameter int SIDE_W          = 8,
  parameter int SZ_W            = 9,
  parameter int RATIO_FRAC_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [15:0]       t_i,
  input  wire logic [15:0]       ratio_i,
  input  wire logic [SZ_W-1:0]   size_i,
  output logic                   done_o,
  output logic                   empty_o,
  output logic      [SIDE_W-1:0] lo_o,
  output logic      [SIDE_W-1:0] hi_o
);

  localparam logic [32:0] ROUND = 33'((64'd1 << RATIO_FRAC_BITS) - 64'd1);

  logic [31:0] prod_q;
  logic        stage_q;
  logic [32:0] first;
  logic [32:0] win_end;
  logic [32:0] last;
  logic [32:0] size_m1;
  logic [32:0] last_cl;
  logic        empty;

  always_comb begin
    first   = 33'(prod_q >> RATIO_FRAC_BITS);
    win_end = ({1'b0, prod_q} + 33'(ratio_i) + ROUND) >> RATIO_FRAC_BITS;
    last    = win_end - 33'd1;
    size_m1 = 33'(size_i) - 33'd1;
    last_cl = (last > size_m1) ? size_m1 : last;
    empty   = (size_i == '0) || (win_end == '0) || (first > last_cl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_o  <= stage_q;
    end
  end

  // The product is registered before the window arithmetic uses it.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= t_i * ratio_i;
    end
    if (stage_q) begin
      empty_o <= empty;
      lo_o    <= first[SIDE_W-1:0];
      hi_o    <= last_cl[SIDE_W-1:0];
    end
  end

endmodule

`default_nettype wire
